/* rtl/bpa_pkg.sv */
// Shared types and constants for the bitmap page allocator.
// No dependencies; bpa_ctrl, bpa_datapath and the top level import this package.
package bpa_pkg;

    // Default built capacity in pages
    localparam int MAX_PAGES_DEF = 1024;

    // Bitmap word width; one memory row holds this many page bits
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 2'd2;

    // Register widths and reset values
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 21;
    localparam int COUNT_W  = 11;
    localparam logic [ADDR_W-1:0]  BASE_RST  = 32'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 21'd4096;
    localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

    // Result beat layout: status in [1:0], granted address in [33:2], zero pad to 40
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_NOT_USED = 2'd3
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    clr_en;
        logic    capture;
        logic    scan_start;
        logic    scan_step;
        logic    alloc_commit;
        logic    grant;
        logic    div_start;
        logic    div_step;
        logic    free_read;
        logic    free_commit;
        logic    res_set;
        status_t res_code;
        logic    out_load;
    } bpa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic func;
        logic addr_bad;
        logic hit;
        logic exhausted;
        logic div_last;
        logic idx_bad;
        logic page_used;
        logic out_free;
    } bpa_stat_t;

endpackage

/* rtl/bpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the page bitmap.
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bpa_ctrl.sv */
// Sequencing state machine of the bitmap page allocator.
// Depends on bpa_pkg; drives the datapath through bpa_cmd_t, reads bpa_stat_t.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bpa_stat_t stat,
    output bpa_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_DECODE    = 10'b0000000100,
        S_SCAN      = 10'b0000001000,
        S_ALLOC_MUL = 10'b0000010000,
        S_ALLOC_ADD = 10'b0000100000,
        S_DIV       = 10'b0001000000,
        S_FREE_CHK  = 10'b0010000000,
        S_FREE_TEST = 10'b0100000000,
        S_RESULT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_code = ST_OK;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!stat.func) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end else if (stat.addr_bad) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_BAD_ADDR;
                    state_next   = S_RESULT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.hit) begin
                    state_next = S_ALLOC_MUL;
                end else if (stat.exhausted) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_FULL;
                    state_next   = S_RESULT;
                end
            end
            S_ALLOC_MUL: begin
                cmd.alloc_commit = 1'b1;
                state_next       = S_ALLOC_ADD;
            end
            S_ALLOC_ADD: begin
                cmd.grant  = 1'b1;
                state_next = S_RESULT;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (stat.idx_bad) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_BAD_ADDR;
                    state_next   = S_RESULT;
                end else begin
                    cmd.free_read = 1'b1;
                    state_next    = S_FREE_TEST;
                end
            end
            S_FREE_TEST: begin
                cmd.res_set = 1'b1;
                if (stat.page_used) begin
                    cmd.free_commit = 1'b1;
                    cmd.res_code    = ST_OK;
                end else begin
                    cmd.res_code = ST_NOT_USED;
                end
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/bpa_datapath.sv */
// Datapath of the bitmap page allocator: config registers, bitmap RAM,
// word scanner, restoring divider, grant multiplier and result register.
// Depends on bpa_pkg and bpa_ram.
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [ADDR_W-1:0]       s_tdata,
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata,
    input  bpa_cmd_t                cmd,
    output bpa_stat_t               stat
);

    localparam int WORDS   = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int NW_W    = $clog2(WORDS + 1);
    localparam int CNT_W   = $clog2(MAX_PAGES + 1);
    localparam int PIDX_W  = WADDR_W + BIT_W;

    // Configuration registers
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_RST;
            size_reg  <= SIZE_RST;
            count_reg <= COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_REGION_BASE: base_reg  <= cfg_wdata[ADDR_W-1:0];
                CFG_PAGE_BYTES:  size_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_PAGE_COUNT:  count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective page size and page count
    logic [SIZE_W-1:0] size_eff;
    logic [CNT_W-1:0]  count_eff;
    logic [31:0]       count32;
    logic [NW_W-1:0]   nwords;

    assign size_eff  = (size_reg == '0) ? SIZE_W'(1) : size_reg;
    assign count_eff = (32'(count_reg) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                         : CNT_W'(count_reg);
    assign count32   = 32'(count_eff);
    assign nwords    = NW_W'((count32 + 32'(WORD_BITS - 1)) >> BIT_W);

    // Captured request
    logic              func_reg;
    logic [ADDR_W-1:0] addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_tuser;
            addr_reg <= s_tdata;
        end
    end

    // Bitmap RAM and its port selection
    logic                 ram_we;
    logic [WADDR_W-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WADDR_W-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (WADDR_W)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clearing pass pointer
    logic [WADDR_W-1:0] clr_ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_ptr_reg <= clr_ptr_reg + WADDR_W'(1);
        end
    end

    // Word scanner: issue one read a cycle, check the word read in the previous cycle
    logic [NW_W-1:0]      rd_ptr_reg;
    logic                 pend_reg;
    logic [WADDR_W-1:0]   chk_word_reg;
    logic                 rd_more;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]     first_free;
    logic                 scan_hit;

    assign rd_more = (rd_ptr_reg < nwords);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            pend_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            pend_reg <= rd_more;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            rd_ptr_reg <= '0;
        end else if (cmd.scan_step && rd_more) begin
            rd_ptr_reg   <= rd_ptr_reg + NW_W'(1);
            chk_word_reg <= rd_ptr_reg[WADDR_W-1:0];
        end
    end

    // Pages at or above the effective count read as used
    always_comb begin
        if (32'(chk_word_reg) < (count32 >> BIT_W)) begin
            word_mask = '1;
        end else begin
            word_mask = (WORD_BITS'(1) << count32[BIT_W-1:0]) - WORD_BITS'(1);
        end
    end

    assign free_bits = ~ram_rdata & word_mask;
    assign scan_hit  = pend_reg && (free_bits != '0);

    // Lowest free bit of the checked word
    always_comb begin
        first_free = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                first_free = BIT_W'(b);
            end
        end
    end

    // Hold the hit word until it is written back
    logic [WADDR_W-1:0]   hit_word_reg;
    logic [BIT_W-1:0]     hit_bit_reg;
    logic [WORD_BITS-1:0] hit_data_reg;
    logic [PIDX_W-1:0]    hit_idx;
    logic [ADDR_W-1:0]    prod_reg;

    always_ff @(posedge aclk) begin
        if (cmd.scan_step && scan_hit) begin
            hit_word_reg <= chk_word_reg;
            hit_bit_reg  <= first_free;
            hit_data_reg <= ram_rdata;
        end
    end

    assign hit_idx = {hit_word_reg, hit_bit_reg};

    // Page offset of the grant, modulo 2^32
    always_ff @(posedge aclk) begin
        if (cmd.alloc_commit) begin
            prod_reg <= 32'(size_eff) * 32'(hit_idx);
        end
    end

    // Restoring divider: offset / page size, one quotient bit a cycle
    logic [ADDR_W-1:0] quo_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [BIT_W-1:0]  div_cnt_reg;
    logic [SIZE_W:0]   rem_sh;
    logic              rem_ge;

    assign rem_sh = {rem_reg, quo_reg[ADDR_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, size_eff});

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            quo_reg     <= addr_reg - base_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg     <= {quo_reg[ADDR_W-2:0], rem_ge};
            rem_reg     <= rem_ge ? SIZE_W'(rem_sh - {1'b0, size_eff}) : SIZE_W'(rem_sh);
            div_cnt_reg <= div_cnt_reg + BIT_W'(1);
        end
    end

    // Free path word and bit
    logic [WADDR_W-1:0] free_word;
    logic [BIT_W-1:0]   free_bit;

    assign free_word = quo_reg[WADDR_W+BIT_W-1:BIT_W];
    assign free_bit  = quo_reg[BIT_W-1:0];

    // RAM port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_ptr_reg;
        ram_wdata = '0;
        if (cmd.clr_en) begin
            ram_we = 1'b1;
        end else if (cmd.alloc_commit) begin
            ram_we    = 1'b1;
            ram_waddr = hit_word_reg;
            ram_wdata = hit_data_reg | (WORD_BITS'(1) << hit_bit_reg);
        end else if (cmd.free_commit) begin
            ram_we    = 1'b1;
            ram_waddr = free_word;
            ram_wdata = ram_rdata & ~(WORD_BITS'(1) << free_bit);
        end
        ram_raddr = cmd.free_read ? free_word : rd_ptr_reg[WADDR_W-1:0];
    end

    // Result register
    status_t           res_status_reg;
    logic [ADDR_W-1:0] res_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_code;
            res_addr_reg   <= '0;
        end else if (cmd.grant) begin
            res_status_reg <= ST_OK;
            res_addr_reg   <= base_reg + prod_reg;
        end
    end

    // Output beat register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {(OUT_DATA_W - ADDR_W - 2)'(0), res_addr_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Status to the controller
    assign stat.clr_last  = (clr_ptr_reg == WADDR_W'(WORDS - 1));
    assign stat.func      = func_reg;
    assign stat.addr_bad  = (addr_reg == '0) || (addr_reg < base_reg);
    assign stat.hit       = scan_hit;
    assign stat.exhausted = !pend_reg && !rd_more;
    assign stat.div_last  = (div_cnt_reg == BIT_W'(ADDR_W - 1));
    assign stat.idx_bad   = (rem_reg != '0) || (quo_reg >= count32);
    assign stat.page_used = ram_rdata[free_bit];
    assign stat.out_free  = !m_valid_reg || m_tready;

endmodule

/* rtl/bitmap_page_allocator.sv */
// Top level of the bitmap first-fit page allocator.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath (which holds bpa_ram).
//
//  channel   direction  ports                      beat contents
//  s_        in         tvalid tready tdata tuser  tdata: page_address; tuser: func
//  m_        out        tvalid tready tdata        tdata: status, granted_address
//  cfg_      in         we index wdata             0 region_base, 1 page_bytes,
//                                                  2 page_count
//
// One request at a time. Allocate scans the bitmap, reading one 32-page word per
// cycle from the RAM read port, until it finds a free page (then a multiply and an
// add form the grant) or has read all ceil(count/32) words and reports full.
// Free runs the 32-step restoring divider, then checks the page index and clears
// its bitmap bit, or goes straight to the result when the address is zero or below the base.
// s_tready rises together with m_tvalid.
// After reset a clearing pass writes zero to every bitmap word, one per cycle,
// with s_tready low; config writes are taken throughout. A result waiting on
// m_tready holds its request in the result state; the next request is taken once
// the beat is loaded.
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ADDR_W-1:0]     s_tdata,   // [31:0] page_address
    input  logic [0:0]            s_tuser,   // [0] func
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [1:0] status, [33:2] granted_address
);

    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    // Sequencer
    bpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Bitmap, divider, multiplier and result path
    bpa_datapath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser[0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
